>>> rtl/pst_pkg.sv
package pst_pkg;

   localparam int ADDR_W  = 32;
   localparam int PROTO_W = 8;
   localparam int PORT_W  = 16;
   localparam int TIME_W  = 32;

   localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

   localparam logic [PORT_W-1:0] THRESHOLD_RESET = 16'd20;
   localparam logic [PORT_W-1:0] PORT_MAX        = 16'hFFFF;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] lo;
      logic [PORT_W-1:0] hi;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

endpackage

>>> rtl/port_scan_tracker.sv
// port scan tracker
// a packet summary word is taken on start while busy is low: destination
// address, protocol, destination port and timestamp. the destination table
// lives in one memory with a registered read. each word walks the
// valid entries one per cycle through the read port until it finds the
// address, keeping the oldest access time on the way, then the write-back
// state updates or replaces the entry and merges a TCP or UDP port into its range.
// busy stays high through the scan (skipped on an empty table) and write-back states.
// exactly one result word follows each packet word, shown for one cycle
// with rsp_valid high in the cycle after the write-back. the receiver cannot
// stall; the result register is free again before the next word completes.
// csr_write_enable loads the scan threshold; the user must write it only while idle, the block does not enforce it.
// synchronous reset empties the table (entry count zero) and loads the
// default threshold of 20; memory contents are left as they are.
module port_scan_tracker #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pst_pkg::ADDR_W-1:0]   req_dest_address,
   input  logic [pst_pkg::PROTO_W-1:0]  req_protocol,
   input  logic [pst_pkg::PORT_W-1:0]   req_dest_port,
   input  logic [pst_pkg::TIME_W-1:0]   req_timestamp,
   output logic                         rsp_valid,
   output logic                         rsp_port_checked,
   output logic                         rsp_scan_detected,
   output logic [pst_pkg::PORT_W-1:0]   rsp_range_width,
   output logic [pst_pkg::ADDR_W-1:0]   rsp_flagged_address,
   input  logic                         csr_write_enable,
   input  logic [pst_pkg::PORT_W-1:0]   csr_write_data
);

   import pst_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(TABLE_DEPTH);

   state_type         state_ff, state_in;
   logic [PORT_W-1:0] threshold_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              chk_ff, chk_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [PORT_W-1:0] hit_lo_ff, hit_lo_in;
   logic [PORT_W-1:0] hit_hi_ff, hit_hi_in;
   logic [TIME_W-1:0] old_time_ff, old_time_in;
   logic [IDX_W-1:0]  old_idx_ff, old_idx_in;

   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [PROTO_W-1:0] proto_ff, proto_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic [TIME_W-1:0]  stamp_ff, stamp_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_checked_ff, rsp_checked_in;
   logic              rsp_scan_ff, rsp_scan_in;
   logic [PORT_W-1:0] rsp_width_ff, rsp_width_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data;
   entry_type         ram_rd_data;

   logic              is_port;
   logic [PORT_W-1:0] lo_base, hi_base, lo_new, hi_new, width_new;
   logic [IDX_W-1:0]  slot;
   logic              last_chk;

   pst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // port merge for the write-back cycle
   always_comb begin
      is_port = (proto_ff == PROTO_TCP) || (proto_ff == PROTO_UDP);
      lo_base = hit_ff ? hit_lo_ff : '0;
      hi_base = hit_ff ? hit_hi_ff : '0;
      lo_new  = lo_base;
      hi_new  = hi_base;
      if (is_port) begin
         if ((hi_base != PORT_MAX) && (port_ff == hi_base + 16'd1)) begin
            hi_new = hi_base + 16'd1;
         end else if ((lo_base != '0) && (port_ff == lo_base - 16'd1)) begin
            lo_new = lo_base - 16'd1;
         end else if ((port_ff < lo_base) || (port_ff > hi_base)) begin
            lo_new = port_ff;
            hi_new = port_ff;
         end
      end
      width_new = hi_new - lo_new;
      if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (count_ff < DEPTH_COUNT) begin
         slot = count_ff[IDX_W-1:0];
      end else begin
         slot = old_idx_ff;
      end
      last_chk = (CNT_W'(chk_idx_ff) == CNT_W'(count_ff - CNT_W'(1)));
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      iss_in         = iss_ff;
      chk_in         = 1'b0;
      chk_idx_in     = chk_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_lo_in      = hit_lo_ff;
      hit_hi_in      = hit_hi_ff;
      old_time_in    = old_time_ff;
      old_idx_in     = old_idx_ff;
      addr_in        = addr_ff;
      proto_in       = proto_ff;
      port_in        = port_ff;
      stamp_in       = stamp_ff;
      rsp_valid_in   = 1'b0;
      rsp_checked_in = rsp_checked_ff;
      rsp_scan_in    = rsp_scan_ff;
      rsp_width_in   = rsp_width_ff;
      rsp_addr_in    = rsp_addr_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = slot;
      ram_wr_data    = '{addr: addr_ff, lo: lo_new, hi: hi_new, stamp: stamp_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               addr_in  = req_dest_address;
               proto_in = req_protocol;
               port_in  = req_dest_port;
               stamp_in = req_timestamp;
               iss_in   = '0;
               hit_in   = 1'b0;
               state_in = (count_ff == '0) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_ff < count_ff) begin
               iss_in     = iss_ff + CNT_W'(1);
               chk_in     = 1'b1;
               chk_idx_in = iss_ff[IDX_W-1:0];
            end
            if (chk_ff) begin
               // oldest entry, first index wins ties
               if ((chk_idx_ff == '0) || (ram_rd_data.stamp < old_time_ff)) begin
                  old_time_in = ram_rd_data.stamp;
                  old_idx_in  = chk_idx_ff;
               end
               if (ram_rd_data.addr == addr_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_lo_in  = ram_rd_data.lo;
                  hit_hi_in  = ram_rd_data.hi;
                  chk_in     = 1'b0;
                  state_in   = ST_WRITE;
               end else if (last_chk) begin
                  chk_in   = 1'b0;
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            ram_wr_en      = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_checked_in = is_port;
            rsp_scan_in    = is_port && (width_new > threshold_ff);
            rsp_width_in   = is_port ? width_new : '0;
            rsp_addr_in    = is_port ? addr_ff : '0;
            if (!hit_ff && (count_ff < DEPTH_COUNT)) begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            threshold_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      iss_ff         <= iss_in;
      chk_idx_ff     <= chk_idx_in;
      hit_idx_ff     <= hit_idx_in;
      hit_lo_ff      <= hit_lo_in;
      hit_hi_ff      <= hit_hi_in;
      old_time_ff    <= old_time_in;
      old_idx_ff     <= old_idx_in;
      addr_ff        <= addr_in;
      proto_ff       <= proto_in;
      port_ff        <= port_in;
      stamp_ff       <= stamp_in;
      rsp_checked_ff <= rsp_checked_in;
      rsp_scan_ff    <= rsp_scan_in;
      rsp_width_ff   <= rsp_width_in;
      rsp_addr_ff    <= rsp_addr_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_port_checked    = rsp_checked_ff;
   assign rsp_scan_detected   = rsp_scan_ff;
   assign rsp_range_width     = rsp_width_ff;
   assign rsp_flagged_address = rsp_addr_ff;

endmodule

>>> rtl/pst_ram.sv
module pst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pst_pkg::*;

   localparam int DEPTH = 1024;
   localparam int POOL = 12;
   localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
   localparam logic [PROTO_W-1:0] PROTO_GRE = 8'd47;

   typedef struct packed {
      logic              checked;
      logic              scan;
      logic [PORT_W-1:0] width;
      logic [ADDR_W-1:0] addr;
   } scan_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ADDR_W-1:0]   req_dest_address = '0;
   logic [PROTO_W-1:0]  req_protocol = '0;
   logic [PORT_W-1:0]   req_dest_port = '0;
   logic [TIME_W-1:0]   req_timestamp = '0;
   logic                rsp_valid;
   logic                rsp_port_checked;
   logic                rsp_scan_detected;
   logic [PORT_W-1:0]   rsp_range_width;
   logic [ADDR_W-1:0]   rsp_flagged_address;
   logic                csr_write_enable = 1'b0;
   logic [PORT_W-1:0]   csr_write_data = '0;

   // destination table as the block should hold it
   logic [ADDR_W-1:0]   dst_addr [DEPTH];
   logic [PORT_W-1:0]   dst_lo [DEPTH];
   logic [PORT_W-1:0]   dst_hi [DEPTH];
   logic [TIME_W-1:0]   dst_seen [DEPTH];
   int                  dst_count = 0;
   logic [PORT_W-1:0]   threshold = THRESHOLD_RESET;

   scan_report_type     report_q [$];
   scan_report_type     exp_report;
   logic [TIME_W-1:0]   stamp_now = '0;
   logic [ADDR_W-1:0]   pool [POOL];
   bit                  sweep_up [POOL];
   bit                  sender_idles = 1'b1;
   int                  errors = 0;

   port_scan_tracker #(
      .TABLE_DEPTH (DEPTH)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_dest_address    (req_dest_address),
      .req_protocol        (req_protocol),
      .req_dest_port       (req_dest_port),
      .req_timestamp       (req_timestamp),
      .rsp_valid           (rsp_valid),
      .rsp_port_checked    (rsp_port_checked),
      .rsp_scan_detected   (rsp_scan_detected),
      .rsp_range_width     (rsp_range_width),
      .rsp_flagged_address (rsp_flagged_address),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int find_entry(input logic [ADDR_W-1:0] addr);
      for (int i = 0; i < dst_count; i++) begin
         if (dst_addr[i] == addr) return i;
      end
      return -1;
   endfunction

   function automatic scan_report_type track_packet(input logic [ADDR_W-1:0] addr,
                                                    input logic [PROTO_W-1:0] proto,
                                                    input logic [PORT_W-1:0] port,
                                                    input logic [TIME_W-1:0] stamp);
      int slot;
      logic [PORT_W-1:0] lo;
      logic [PORT_W-1:0] hi;
      scan_report_type r;
      slot = find_entry(addr);
      if (slot < 0) begin
         if (dst_count < DEPTH) begin
            slot = dst_count;
            dst_count++;
         end else begin
            // oldest access wins, lowest index on ties
            slot = 0;
            for (int i = 1; i < DEPTH; i++) begin
               if (dst_seen[i] < dst_seen[slot]) slot = i;
            end
         end
         dst_addr[slot] = addr;
         dst_lo[slot] = '0;
         dst_hi[slot] = '0;
      end
      dst_seen[slot] = stamp;
      r = '0;
      if (proto == PROTO_TCP || proto == PROTO_UDP) begin
         lo = dst_lo[slot];
         hi = dst_hi[slot];
         if (hi != PORT_MAX && port == hi + 16'd1) begin
            dst_hi[slot] = hi + 16'd1;
         end else if (lo != '0 && port == lo - 16'd1) begin
            dst_lo[slot] = lo - 16'd1;
         end else if (port < lo || port > hi) begin
            dst_lo[slot] = port;
            dst_hi[slot] = port;
         end
         r.checked = 1'b1;
         r.width = dst_hi[slot] - dst_lo[slot];
         r.scan = (r.width > threshold);
         r.addr = addr;
      end
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] next_stamp();
      stamp_now = stamp_now + $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) return $urandom;
      return stamp_now;
   endfunction

   function automatic logic [PROTO_W-1:0] pick_protocol();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return PROTO_TCP;
      if (r < 7) return PROTO_UDP;
      return PROTO_W'($urandom_range(0, 255));
   endfunction

   // small stamps so that ties in the oldest-entry search are common
   function automatic logic [TIME_W-1:0] crowded_stamp();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return $urandom_range(0, 15);
   endfunction

   task automatic send_word(input logic [ADDR_W-1:0] addr, input logic [PROTO_W-1:0] proto,
                            input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] stamp);
      start <= 1'b1;
      req_dest_address <= addr;
      req_protocol <= proto;
      req_dest_port <= port;
      req_timestamp <= stamp;
      @(posedge clock);
      while (busy) @(posedge clock);
      report_q.push_back(track_packet(addr, proto, port, stamp));
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (report_q.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [PORT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      threshold = value;
   endtask

   task automatic test_new_entries();
      sender_idles = 1'b1;
      send_word(32'h0000_0000, PROTO_TCP, 16'd0, 32'h0000_0000);
      send_word(32'h0000_0000, PROTO_TCP, 16'd1, next_stamp());
      send_word(32'h0000_0000, PROTO_UDP, 16'd0, next_stamp());
      send_word(32'h0000_0000, PROTO_TCP, 16'd3, next_stamp());
      send_word(32'h0000_0000, PROTO_TCP, 16'd2, next_stamp());
      send_word(32'h0000_0000, PROTO_UDP, 16'd4, 32'hFFFF_FFFF);
   endtask

   task automatic test_port_limits();
      send_word(32'hFFFF_FFFF, PROTO_UDP, PORT_MAX, next_stamp());
      send_word(32'hFFFF_FFFF, PROTO_UDP, PORT_MAX, next_stamp());
      send_word(32'hFFFF_FFFF, PROTO_TCP, PORT_MAX - 16'd1, next_stamp());
      send_word(32'h0000_0001, PROTO_TCP, 16'd1, next_stamp());
      send_word(32'h0000_0001, PROTO_TCP, 16'd0, next_stamp());
      send_word(32'h0000_0001, PROTO_UDP, PORT_MAX, next_stamp());
   endtask

   task automatic test_other_protocols();
      send_word(32'h8000_0000, 8'h00, PORT_MAX, next_stamp());
      send_word(32'h8000_0000, 8'hFF, 16'd5, next_stamp());
      send_word(32'h0000_0000, PROTO_ICMP, 16'd9, next_stamp());
      send_word(32'h8000_0000, PROTO_TCP, 16'd1, next_stamp());
      send_word(32'hFFFF_FFFF, PROTO_GRE, 16'd0, next_stamp());
   endtask

   task automatic test_threshold_edges();
      wait_idle();
      set_threshold(16'd0);
      send_word(32'hC0A8_0001, PROTO_TCP, 16'd0, next_stamp());
      send_word(32'hC0A8_0001, PROTO_TCP, 16'd1, next_stamp());
      wait_idle();
      set_threshold(16'd2);
      send_word(32'hC0A8_0001, PROTO_UDP, 16'd2, next_stamp());
      send_word(32'hC0A8_0001, PROTO_UDP, 16'd3, next_stamp());
      wait_idle();
      set_threshold(PORT_MAX);
      send_word(32'hC0A8_0001, PROTO_TCP, 16'd4, next_stamp());
   endtask

   task automatic test_random_traffic(input int n_words, input logic [PORT_W-1:0] thr);
      int sent;
      int len;
      int s;
      int idx;
      int r;
      logic [ADDR_W-1:0] addr;
      logic [PROTO_W-1:0] proto;
      logic [PORT_W-1:0] port;
      wait_idle();
      set_threshold(thr);
      sent = 0;
      while (sent < n_words) begin
         sender_idles = ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 99) < 65) begin
            // port sweep on one destination
            s = $urandom_range(0, POOL - 1);
            len = $urandom_range(4, 30);
            for (int k = 0; k < len; k++) begin
               idx = find_entry(pool[s]);
               proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
               if (idx < 0 || $urandom_range(0, 29) == 0) begin
                  r = $urandom_range(0, 3);
                  port = (r == 0) ? 16'd0 : (r == 1) ? PORT_MAX :
                         PORT_W'($urandom_range(0, 65535));
               end else begin
                  if (sweep_up[s] && dst_hi[idx] == PORT_MAX) sweep_up[s] = 1'b0;
                  if (!sweep_up[s] && dst_lo[idx] == '0) sweep_up[s] = 1'b1;
                  port = sweep_up[s] ? dst_hi[idx] + 16'd1 : dst_lo[idx] - 16'd1;
                  r = $urandom_range(0, 19);
                  if (r == 0) begin
                     proto = PROTO_W'($urandom_range(0, 255));
                  end else if (r == 1) begin
                     port = dst_lo[idx] + ((dst_hi[idx] - dst_lo[idx]) >> 1);
                  end
               end
               send_word(pool[s], proto, port, next_stamp());
               sent++;
            end
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               addr = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL - 1)];
               send_word(addr, pick_protocol(), PORT_W'($urandom_range(0, 65535)),
                         next_stamp());
               sent++;
            end
         end
      end
   endtask

   task automatic test_full_table();
      logic [ADDR_W-1:0] addr;
      wait_idle();
      set_threshold(PORT_W'($urandom_range(0, 8)));
      sender_idles = 1'b0;
      while (dst_count < DEPTH) begin
         do addr = $urandom; while (find_entry(addr) >= 0);
         send_word(addr, pick_protocol(), PORT_W'($urandom_range(0, 65535)), crowded_stamp());
      end
      // table full: new destinations replace the oldest entry
      for (int k = 0; k < 48; k++) begin
         if ($urandom_range(0, 9) < 6) begin
            do addr = $urandom; while (find_entry(addr) >= 0);
         end else begin
            addr = dst_addr[$urandom_range(0, DEPTH - 1)];
         end
         send_word(addr, pick_protocol(), PORT_W'($urandom_range(0, 65535)), crowded_stamp());
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (report_q.size() == 0) begin
            $error("result word with no word outstanding");
            errors++;
         end else begin
            exp_report = report_q.pop_front();
            if (rsp_port_checked !== exp_report.checked) begin
               $error("port_checked expected %0d got %0d", exp_report.checked,
                      rsp_port_checked);
               errors++;
            end
            if (rsp_scan_detected !== exp_report.scan) begin
               $error("scan_detected expected %0d got %0d", exp_report.scan,
                      rsp_scan_detected);
               errors++;
            end
            if (rsp_range_width !== exp_report.width) begin
               $error("range_width expected %0d got %0d", exp_report.width, rsp_range_width);
               errors++;
            end
            if (rsp_flagged_address !== exp_report.addr) begin
               $error("flagged_address expected %h got %h", exp_report.addr,
                      rsp_flagged_address);
               errors++;
            end
         end
      end
   end

   initial begin
      pool[0] = 32'h0000_0000;
      pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL; i++) pool[i] = $urandom;
      for (int i = 0; i < POOL; i++) sweep_up[i] = 1'($urandom_range(0, 1));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_new_entries();
      test_port_limits();
      test_other_protocols();
      test_threshold_edges();
      test_random_traffic(116, THRESHOLD_RESET);
      test_random_traffic(116, 16'd0);
      test_random_traffic(116, PORT_MAX);
      test_random_traffic(116, PORT_W'($urandom_range(1, 12)));
      test_random_traffic(116, PORT_W'($urandom_range(13, 40)));
      test_full_table();
      start <= 1'b0;
      for (int k = 0; k < 4 * DEPTH && report_q.size() != 0; k++) @(posedge clock);
      repeat (16) @(posedge clock);
      if (report_q.size() != 0) begin
         $error("%0d result words never arrived", report_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("port_scan_tracker: match");
      end else begin
         $display("port_scan_tracker: mismatch");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("port_scan_tracker: mismatch");
      $finish;
   end

endmodule

>>> port_scan_tracker.f
rtl/pst_pkg.sv
rtl/pst_ram.sv
rtl/port_scan_tracker.sv
sim/tb_top.sv
